// File: design/bcs_pkg.sv
// Shared types and constants of the battery charge supervisor.
package bcs_pkg;

    // Charge state codes as they appear on the result channel
    localparam logic [2:0] CS_EMPTY    = 3'd0;
    localparam logic [2:0] CS_PRECHECK = 3'd1;
    localparam logic [2:0] CS_ACTIVE   = 3'd2;
    localparam logic [2:0] CS_COMPLETE = 3'd3;
    localparam logic [2:0] CS_FAULT    = 3'd4;

    // Bit positions in the sticky fault mask
    localparam int unsigned FB_CLOCK    = 0;
    localparam int unsigned FB_IDENTITY = 1;
    localparam int unsigned FB_SENSOR   = 2;
    localparam int unsigned FB_TEMP     = 3;
    localparam int unsigned FB_VOLTAGE  = 4;
    localparam int unsigned FB_CHARGER  = 5;
    localparam int unsigned FB_TIMEOUT  = 6;
    localparam int unsigned FAULT_W     = 7;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_TEMP    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_TEMP    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_VOLTAGE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_VOLTAGE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_TIME    = 3'd4;

    // Configuration reset values
    localparam logic signed [15:0] MIN_TEMP_RST    = 16'sd0;
    localparam logic signed [15:0] MAX_TEMP_RST    = 16'sd450;
    localparam logic [15:0]        MIN_VOLTAGE_RST = 16'd3000;
    localparam logic [15:0]        MAX_VOLTAGE_RST = 16'd4200;
    localparam logic [31:0]        MAX_TIME_RST    = 32'd14400000;

    // One supervision tick
    typedef struct packed {
        logic [63:0]        now_time;
        logic               pack_fitted;
        logic               identity_ok;
        logic               sensors_ok;
        logic signed [15:0] temperature;
        logic [15:0]        pack_voltage;
        logic               charger_error;
        logic               charge_done;
    } tick_t;

    // One supervision result
    typedef struct packed {
        logic [2:0]         charge_state;
        logic               enable_charging;
        logic [FAULT_W-1:0] fault_bits;
        logic [31:0]        faults_seen;
        logic [31:0]        charges_completed;
    } result_t;

endpackage

// File: design/bcs_if.sv
// Channel interfaces of the battery charge supervisor: ticks, results, configuration.
interface bcs_tick_if;
    import bcs_pkg::*;

    logic  valid;
    logic  ready;
    tick_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bcs_status_if;
    import bcs_pkg::*;

    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bcs_cfg_if;
    import bcs_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/battery_charge_supervisor.sv
// Battery charge supervisor: tick register, state update and result register.
//
//  channel | dir | payload                                   | transaction
//  --------+-----+-------------------------------------------+-----------------------
//  tick    | in  | now_time, flags, temperature, pack_voltage| valid && ready
//  status  | out | charge_state, enable, faults, counters    | valid && ready
//  cfg     | in  | index, data                               | valid && ready
//
// A tick is held in the tick register, then the state update and the result are
// computed in one pass and stored in the result register; one tick per cycle is
// sustained while results are taken. The 64-bit elapsed-time subtract and
// compare set the cycle time. Reset returns the state machine, counters and
// configuration registers to their reset values. A stalled result holds the tick
// register, so the input stalls once both registers are full; configuration
// writes are always taken.
module battery_charge_supervisor (
    input  logic             clk,
    input  logic             rst_n,
    bcs_tick_if.sink         tick,
    bcs_status_if.source     status,
    bcs_cfg_if.sink          cfg
);
    import bcs_pkg::*;

    typedef enum logic [2:0] {
        ST_EMPTY    = CS_EMPTY,
        ST_PRECHECK = CS_PRECHECK,
        ST_ACTIVE   = CS_ACTIVE,
        ST_COMPLETE = CS_COMPLETE,
        ST_FAULT    = CS_FAULT
    } state_t;

    // Configuration registers
    logic signed [15:0] min_temp_reg;
    logic signed [15:0] max_temp_reg;
    logic [15:0]        min_voltage_reg;
    logic [15:0]        max_voltage_reg;
    logic [31:0]        max_time_reg;

    // Tick register
    logic  tick_valid_reg;
    tick_t tick_reg;

    // Supervisor state
    state_t             state_reg,       state_next;
    logic [63:0]        entry_time_reg,  entry_time_next;
    logic [63:0]        last_time_reg,   last_time_next;
    logic [FAULT_W-1:0] faults_reg,      faults_next;
    logic [31:0]        fault_count_reg, fault_count_next;
    logic [31:0]        done_count_reg,  done_count_next;
    logic               enable_next;

    // Result register
    logic    out_valid_reg;
    result_t out_reg;

    // Check terms
    logic               advance;
    logic               clock_back;
    logic               temp_bad;
    logic               voltage_bad;
    logic               timed_out;
    logic [63:0]        elapsed;
    logic [FAULT_W-1:0] fault_hit;

    // Handshakes
    assign advance      = tick_valid_reg && (!out_valid_reg || status.ready);
    assign tick.ready   = !tick_valid_reg || advance;
    assign status.valid = out_valid_reg;
    assign status.payload = out_reg;
    assign cfg.ready    = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_temp_reg    <= MIN_TEMP_RST;
            max_temp_reg    <= MAX_TEMP_RST;
            min_voltage_reg <= MIN_VOLTAGE_RST;
            max_voltage_reg <= MAX_VOLTAGE_RST;
            max_time_reg    <= MAX_TIME_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MIN_TEMP:    min_temp_reg    <= signed'(cfg.data[15:0]);
                REG_MAX_TEMP:    max_temp_reg    <= signed'(cfg.data[15:0]);
                REG_MIN_VOLTAGE: min_voltage_reg <= cfg.data[15:0];
                REG_MAX_VOLTAGE: max_voltage_reg <= cfg.data[15:0];
                REG_MAX_TIME:    max_time_reg    <= cfg.data;
                default:         ;
            endcase
        end
    end

    // Tick register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            tick_valid_reg <= tick.valid;
        end
    end

    // Tick register payload
    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            tick_reg <= tick.payload;
        end
    end

    // Check terms of the held tick
    assign clock_back  = tick_reg.now_time < last_time_reg;
    assign elapsed     = tick_reg.now_time - entry_time_reg;
    assign timed_out   = (state_reg == ST_ACTIVE) && (elapsed > {32'd0, max_time_reg});
    assign temp_bad    = (tick_reg.temperature < min_temp_reg)
                      || (tick_reg.temperature > max_temp_reg);
    assign voltage_bad = (tick_reg.pack_voltage < min_voltage_reg)
                      || (tick_reg.pack_voltage > max_voltage_reg);

    // Fault selection in priority order; at most one bit is set
    always_comb
    begin
        fault_hit = '0;
        if (clock_back)
        begin
            fault_hit[FB_CLOCK] = 1'b1;
        end
        else if (tick_reg.pack_fitted && (state_reg != ST_FAULT))
        begin
            if (!tick_reg.identity_ok)
                fault_hit[FB_IDENTITY] = 1'b1;
            else if (!tick_reg.sensors_ok)
                fault_hit[FB_SENSOR] = 1'b1;
            else if (temp_bad)
                fault_hit[FB_TEMP] = 1'b1;
            else if (voltage_bad)
                fault_hit[FB_VOLTAGE] = 1'b1;
            else if (tick_reg.charger_error)
                fault_hit[FB_CHARGER] = 1'b1;
            else if (timed_out)
                fault_hit[FB_TIMEOUT] = 1'b1;
        end
    end

    // State update for the held tick
    always_comb
    begin
        state_next       = state_reg;
        entry_time_next  = entry_time_reg;
        last_time_next   = last_time_reg;
        faults_next      = faults_reg;
        fault_count_next = fault_count_reg;
        done_count_next  = done_count_reg;
        enable_next      = 1'b0;

        if (!clock_back)
        begin
            last_time_next = tick_reg.now_time;
        end

        if (fault_hit != '0)
        begin
            // Entering fault: count and stamp only on the first entry
            faults_next = faults_reg | fault_hit;
            if (state_reg != ST_FAULT)
            begin
                fault_count_next = fault_count_reg + 32'd1;
                state_next       = ST_FAULT;
                entry_time_next  = tick_reg.now_time;
            end
        end
        else if (!tick_reg.pack_fitted)
        begin
            // Pack removed clears the faults
            faults_next = '0;
            if (state_reg != ST_EMPTY)
            begin
                state_next      = ST_EMPTY;
                entry_time_next = tick_reg.now_time;
            end
        end
        else if (state_reg != ST_FAULT)
        begin
            if (tick_reg.charge_done)
            begin
                if (state_reg == ST_ACTIVE)
                begin
                    done_count_next = done_count_reg + 32'd1;
                end
                if (state_reg != ST_COMPLETE)
                begin
                    state_next      = ST_COMPLETE;
                    entry_time_next = tick_reg.now_time;
                end
            end
            else if (state_reg == ST_EMPTY)
            begin
                state_next      = ST_PRECHECK;
                entry_time_next = tick_reg.now_time;
            end
            else
            begin
                enable_next = 1'b1;
                if (state_reg != ST_ACTIVE)
                begin
                    state_next      = ST_ACTIVE;
                    entry_time_next = tick_reg.now_time;
                end
            end
        end
    end

    // State machine and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_EMPTY;
            entry_time_reg  <= '0;
            last_time_reg   <= '0;
            faults_reg      <= '0;
            fault_count_reg <= '0;
            done_count_reg  <= '0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
        end
        else
        begin
            if (advance)
            begin
                state_reg       <= state_next;
                entry_time_reg  <= entry_time_next;
                last_time_reg   <= last_time_next;
                faults_reg      <= faults_next;
                fault_count_reg <= fault_count_next;
                done_count_reg  <= done_count_next;
                out_reg.charge_state      <= state_next;
                out_reg.enable_charging   <= enable_next;
                out_reg.fault_bits        <= faults_next;
                out_reg.faults_seen       <= fault_count_next;
                out_reg.charges_completed <= done_count_next;
                out_valid_reg   <= 1'b1;
            end
            else if (status.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: design/bcs_checker.sv
// Port-level checks of the battery charge supervisor and their bind.
module bcs_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input bcs_pkg::result_t out_data
);
    import bcs_pkg::*;

    logic    out_xfer;
    logic    prev_valid_reg;
    result_t prev_reg;

    assign out_xfer = out_valid && out_ready;

    // Remember the last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg <= 1'b0;
            prev_reg       <= '0;
        end
        else if (out_xfer)
        begin
            prev_valid_reg <= 1'b1;
            prev_reg       <= out_data;
        end
    end

    // A stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

    // Charging is enabled only in the active state
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.enable_charging |-> out_data.charge_state == CS_ACTIVE)
    else $error("charging enabled outside the active state");

    // Sticky faults are present exactly while in the fault state
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.fault_bits != '0) == (out_data.charge_state == CS_FAULT)))
    else $error("fault mask disagrees with the fault state");

    // Each transaction advances either counter by at most one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && prev_valid_reg |->
            (out_data.faults_seen == prev_reg.faults_seen
             || out_data.faults_seen == prev_reg.faults_seen + 32'd1)
            && (out_data.charges_completed == prev_reg.charges_completed
             || out_data.charges_completed == prev_reg.charges_completed + 32'd1))
    else $error("counter jumped by more than one");

endmodule

bind battery_charge_supervisor bcs_checker u_bcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (status.valid),
    .out_ready (status.ready),
    .out_data  (status.payload)
);

// File: tb/tb_battery_charge_supervisor.sv
// Self-checking testbench of the battery charge supervisor, with its own state predictor.
`timescale 1ns / 1ps

module tb_battery_charge_supervisor;
    import bcs_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 300000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned LONG_HOLD     = 200;
    localparam int unsigned HOLD_AFTER    = 300;

    // Kinds of disturbance that a charge session can end with
    typedef enum int {
        INJ_CLOCK,
        INJ_IDENTITY,
        INJ_SENSOR,
        INJ_TEMP,
        INJ_VOLTAGE,
        INJ_CHARGER,
        INJ_TIMEOUT,
        INJ_LONG_STEP
    } inject_e;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Testbench-side copies of every block input, known from time zero
    logic                   send_valid = 1'b0;
    tick_t                  send_item = '0;
    logic                   take_ready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_MIN_TEMP;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    bcs_tick_if   tick_ch ();
    bcs_status_if status_ch ();
    bcs_cfg_if    cfg_ch ();

    assign tick_ch.valid   = send_valid;
    assign tick_ch.payload = send_item;
    assign status_ch.ready = take_ready;
    assign cfg_ch.valid    = cfg_valid;
    assign cfg_ch.index    = cfg_index;
    assign cfg_ch.data     = cfg_data;

    battery_charge_supervisor u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .status (status_ch),
        .cfg    (cfg_ch)
    );

    // Predicted supervisor state and limits
    logic signed [15:0] min_temp;
    logic signed [15:0] max_temp;
    logic [15:0]        min_mv;
    logic [15:0]        max_mv;
    logic [31:0]        max_active_ms;
    logic [2:0]         chg_state;
    logic [63:0]        entry_ms;
    logic [63:0]        latest_ms;
    logic [FAULT_W-1:0] fault_flags;
    logic [31:0]        fault_entries;
    logic [31:0]        charge_count;
    logic               charging;

    tick_t   pend_q[$];
    result_t status_q[$];

    // Stimulus and bookkeeping
    logic [63:0] clock_ms = '0;
    logic [63:0] prev_ms = '0;
    int unsigned ticks_queued = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned settings_applied = 0;
    int unsigned cycle_count = 0;
    bit          idle_on = 1'b1;
    logic        tick_sent = 1'b0;
    int unsigned send_gap = 0;
    int unsigned take_gap = 0;
    int unsigned hold_left = 0;
    bit          held_once = 1'b0;

    // Clock generation.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Cycle counter that ends a hung run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped at the cycle limit with %0d results outstanding.",
                 status_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Predictor helpers: state change keeps the entry time unless the state moves.
    function automatic void move_to(logic [2:0] next, logic [63:0] now);
        if (chg_state != next)
        begin
            chg_state = next;
            entry_ms  = now;
        end
    endfunction

    function automatic void enter_fault(int unsigned bit_pos, logic [63:0] now);
        if (chg_state != CS_FAULT)
            fault_entries = fault_entries + 32'd1;
        fault_flags = fault_flags | (FAULT_W'(1) << bit_pos);
        charging   = 1'b0;
        move_to(CS_FAULT, now);
    endfunction

    // Works out the status that one supervision tick leaves behind.
    function automatic result_t predict_status(tick_t t);
        result_t r;
        charging = 1'b0;
        if (t.now_time < latest_ms)
            enter_fault(FB_CLOCK, t.now_time);
        else
        begin
            latest_ms = t.now_time;
            if (!t.pack_fitted)
            begin
                fault_flags = '0;
                move_to(CS_EMPTY, t.now_time);
            end
            else if (chg_state != CS_FAULT)
            begin
                if (!t.identity_ok)
                    enter_fault(FB_IDENTITY, t.now_time);
                else if (!t.sensors_ok)
                    enter_fault(FB_SENSOR, t.now_time);
                else if ($signed(t.temperature) < min_temp ||
                         $signed(t.temperature) > max_temp)
                    enter_fault(FB_TEMP, t.now_time);
                else if (t.pack_voltage < min_mv || t.pack_voltage > max_mv)
                    enter_fault(FB_VOLTAGE, t.now_time);
                else if (t.charger_error)
                    enter_fault(FB_CHARGER, t.now_time);
                else if (chg_state == CS_ACTIVE &&
                         (t.now_time - entry_ms) > {32'd0, max_active_ms})
                    enter_fault(FB_TIMEOUT, t.now_time);
                else if (t.charge_done)
                begin
                    if (chg_state == CS_ACTIVE)
                        charge_count = charge_count + 32'd1;
                    move_to(CS_COMPLETE, t.now_time);
                end
                else if (chg_state == CS_EMPTY)
                    move_to(CS_PRECHECK, t.now_time);
                else
                begin
                    move_to(CS_ACTIVE, t.now_time);
                    charging = 1'b1;
                end
            end
        end
        r.charge_state      = chg_state;
        r.enable_charging   = charging;
        r.fault_bits        = fault_flags;
        r.faults_seen       = fault_entries;
        r.charges_completed = charge_count;
        return r;
    endfunction

    task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, fname, want, got);
        end
    endtask

    // Tick driver: holds an offered tick until it is taken, idles in bursts.
    always @(negedge clk)
    begin
        if (rst_n && (!send_valid || tick_sent))
        begin
            if (send_gap > 0)
            begin
                send_gap   <= send_gap - 1;
                send_valid <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                send_gap   <= $urandom_range(0, 15);
                send_valid <= 1'b0;
            end
            else if (pend_q.size() > 0)
            begin
                send_item  <= pend_q.pop_front();
                send_valid <= 1'b1;
            end
            else
                send_valid <= 1'b0;
        end
    end

    // Result receiver: random stalls plus one long hold-off to back the block up.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left  <= hold_left - 1;
                take_ready <= 1'b0;
            end
            else if (!held_once && results_seen >= HOLD_AFTER)
            begin
                held_once  <= 1'b1;
                hold_left  <= LONG_HOLD - 1;
                take_ready <= 1'b0;
            end
            else if (take_gap > 0)
            begin
                take_gap   <= take_gap - 1;
                take_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                take_gap   <= $urandom_range(0, 15);
                take_ready <= 1'b0;
            end
            else
                take_ready <= 1'b1;
        end
    end

    // Monitor: predicts on each tick transaction and checks each status transaction.
    always @(posedge clk)
    begin : monitor
        result_t want;
        tick_sent <= rst_n && tick_ch.valid && tick_ch.ready;
        if (rst_n && tick_ch.valid && tick_ch.ready)
            status_q.push_back(predict_status(tick_ch.payload));
        if (rst_n && status_ch.valid && status_ch.ready)
        begin
            results_seen++;
            if (status_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: status transaction with nothing expected, got 0x%0h",
                         $time, status_ch.payload);
            end
            else
            begin
                want = status_q.pop_front();
                check_field("charge_state", want.charge_state,
                            status_ch.payload.charge_state);
                check_field("enable_charging", want.enable_charging,
                            status_ch.payload.enable_charging);
                check_field("fault_bits", want.fault_bits,
                            status_ch.payload.fault_bits);
                check_field("faults_seen", want.faults_seen,
                            status_ch.payload.faults_seen);
                check_field("charges_completed", want.charges_completed,
                            status_ch.payload.charges_completed);
            end
        end
    end

    task automatic queue_tick(logic [63:0] now, bit present, bit ident, bit sens,
                              logic [15:0] temp, logic [15:0] volt, bit err, bit done);
        tick_t t;
        t.now_time      = now;
        t.pack_fitted   = present;
        t.identity_ok   = ident;
        t.sensors_ok    = sens;
        t.temperature   = temp;
        t.pack_voltage  = volt;
        t.charger_error = err;
        t.charge_done   = done;
        pend_q.push_back(t);
        ticks_queued++;
    endtask

    // Readings drawn inside or just outside the current windows.
    function automatic logic [15:0] temp_inside();
        int lo;
        int hi;
        lo = int'(min_temp);
        hi = int'(max_temp);
        if (lo > hi)
            return 16'($urandom);
        return 16'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    function automatic logic [15:0] temp_outside();
        int lo;
        int hi;
        lo = int'(min_temp);
        hi = int'(max_temp);
        if (lo > hi)
            return 16'($urandom);
        if (hi == 32767 || (lo > -32768 && $urandom_range(0, 1) == 0))
            return ($urandom_range(0, 3) == 0) ? 16'h8000 : 16'(lo - 1);
        return ($urandom_range(0, 3) == 0) ? 16'h7FFF : 16'(hi + 1);
    endfunction

    function automatic logic [15:0] volt_inside();
        int lo;
        int hi;
        lo = int'(min_mv);
        hi = int'(max_mv);
        if (lo > hi)
            return 16'($urandom);
        return 16'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    function automatic logic [15:0] volt_outside();
        int lo;
        int hi;
        lo = int'(min_mv);
        hi = int'(max_mv);
        if (lo > hi)
            return 16'($urandom);
        if (hi == 65535 || (lo > 0 && $urandom_range(0, 1) == 0))
            return ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'(lo - 1);
        return ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'(hi + 1);
    endfunction

    // A healthy tick at or a little after the time of the previous one.
    function automatic tick_t healthy_tick();
        tick_t t;
        prev_ms = clock_ms;
        if ($urandom_range(0, 3) != 0)
            clock_ms = clock_ms + 64'($urandom_range(1, 500));
        t.now_time      = clock_ms;
        t.pack_fitted   = 1'b1;
        t.identity_ok   = 1'b1;
        t.sensors_ok    = 1'b1;
        t.temperature   = temp_inside();
        t.pack_voltage  = volt_inside();
        t.charger_error = 1'b0;
        t.charge_done   = 1'b0;
        return t;
    endfunction

    function automatic tick_t noisy_tick();
        tick_t t;
        t = healthy_tick();
        if ($urandom_range(0, 7) == 0 && prev_ms > 500)
            t.now_time = prev_ms - 64'($urandom_range(1, 500));
        t.pack_fitted   = 1'($urandom_range(0, 1));
        t.identity_ok   = $urandom_range(0, 3) != 0;
        t.sensors_ok    = $urandom_range(0, 3) != 0;
        t.temperature   = 16'($urandom);
        t.pack_voltage  = 16'($urandom);
        t.charger_error = 1'($urandom_range(0, 1));
        t.charge_done   = 1'($urandom_range(0, 1));
        return t;
    endfunction

    // Spoils a healthy tick with one disturbance, sometimes with random charger-error and charge-done flags too.
    function automatic tick_t disturb(tick_t t);
        inject_e kind;
        bit      full_temp;
        bit      full_volt;
        kind      = inject_e'($urandom_range(0, INJ_LONG_STEP));
        full_temp = (min_temp == 16'sh8000) && (max_temp == 16'sh7FFF);
        full_volt = (min_mv == 16'h0000) && (max_mv == 16'hFFFF);
        if ($urandom_range(0, 2) == 0)
        begin
            t.charger_error = 1'($urandom_range(0, 1));
            t.charge_done   = 1'($urandom_range(0, 1));
        end
        case (kind)
            INJ_CLOCK:
                t.now_time = (prev_ms > 500) ? prev_ms - 64'($urandom_range(1, 500)) : '0;
            INJ_IDENTITY:
                t.identity_ok = 1'b0;
            INJ_SENSOR:
                t.sensors_ok = 1'b0;
            INJ_TEMP:
                if (full_temp)
                    t.sensors_ok = 1'b0;
                else
                    t.temperature = temp_outside();
            INJ_VOLTAGE:
                if (full_volt)
                    t.sensors_ok = 1'b0;
                else
                    t.pack_voltage = volt_outside();
            INJ_CHARGER:
                t.charger_error = 1'b1;
            INJ_TIMEOUT:
            begin
                clock_ms   = prev_ms + {32'd0, max_active_ms} + 64'($urandom_range(1, 50));
                t.now_time = clock_ms;
            end
            default:
            begin
                clock_ms   = prev_ms + {32'd0, max_active_ms};
                t.now_time = clock_ms;
            end
        endcase
        return t;
    endfunction

    task automatic push_item(tick_t t);
        pend_q.push_back(t);
        ticks_queued++;
    endtask

    // One charge session: pack absent, then healthy ticks, maybe done, maybe a fault; or a run of noisy ticks.
    task automatic gen_session();
        tick_t       t;
        int unsigned n;
        n = $urandom_range(2, 14);
        if ($urandom_range(0, 9) == 0)
        begin
            repeat (n)
                push_item(noisy_tick());
            return;
        end
        t = healthy_tick();
        t.pack_fitted  = 1'b0;
        t.temperature  = 16'($urandom);
        t.pack_voltage = 16'($urandom);
        push_item(t);
        for (int unsigned i = 1; i < n; i++)
        begin
            t = healthy_tick();
            if ((i == n - 1 && $urandom_range(0, 1) == 0) || $urandom_range(0, 15) == 0)
                t.charge_done = 1'b1;
            if ($urandom_range(0, 9) == 0)
            begin
                push_item(disturb(t));
                repeat ($urandom_range(0, 2))
                    push_item(healthy_tick());
                break;
            end
            push_item(t);
        end
    endtask

    task automatic gen_phase(int unsigned count);
        int unsigned target;
        target = ticks_queued + count;
        while (ticks_queued < target)
            gen_session();
    endtask

    // Waits until every tick has been answered and the pipeline has drained.
    task automatic wait_idle();
        while (pend_q.size() != 0 || send_valid || status_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_MIN_TEMP:    min_temp      = val[15:0];
            REG_MAX_TEMP:    max_temp      = val[15:0];
            REG_MIN_VOLTAGE: min_mv        = val[15:0];
            REG_MAX_VOLTAGE: max_mv        = val[15:0];
            REG_MAX_TIME:    max_active_ms = val;
            default:         ;
        endcase
    endtask

    // Writes a full set of limits once the block is idle.
    task automatic apply_limits(logic signed [15:0] t_lo, logic signed [15:0] t_hi,
                                logic [15:0] v_lo, logic [15:0] v_hi, logic [31:0] ms);
        wait_idle();
        write_reg(REG_MIN_TEMP, {{16{t_lo[15]}}, t_lo});
        write_reg(REG_MAX_TEMP, {{16{t_hi[15]}}, t_hi});
        write_reg(REG_MIN_VOLTAGE, {16'd0, v_lo});
        write_reg(REG_MAX_VOLTAGE, {16'd0, v_hi});
        write_reg(REG_MAX_TIME, ms);
        @(negedge clk);
        cfg_valid = 1'b0;
        settings_applied++;
    endtask

    // Main sequence: reset, directed ticks, then random phases under several limit sets.
    initial
    begin
        min_temp      = MIN_TEMP_RST;
        max_temp      = MAX_TEMP_RST;
        min_mv        = MIN_VOLTAGE_RST;
        max_mv        = MAX_VOLTAGE_RST;
        max_active_ms = MAX_TIME_RST;
        chg_state     = CS_EMPTY;
        entry_ms      = '0;
        latest_ms     = '0;
        fault_flags   = '0;
        fault_entries = '0;
        charge_count  = '0;
        charging      = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: window edges, timeout edge, every fault, fault while in fault.
        apply_limits(16'sd0, 16'sd450, 16'd3000, 16'd4200, 32'd100);
        queue_tick(64'd10, 0, 1, 1, 16'd250, 16'd3700, 0, 0);
        queue_tick(64'd20, 1, 1, 1, 16'd0, 16'd3000, 0, 0);
        queue_tick(64'd30, 1, 1, 1, 16'd450, 16'd4200, 0, 0);
        queue_tick(64'd130, 1, 1, 1, 16'd250, 16'd3700, 0, 0);
        queue_tick(64'd131, 1, 1, 1, 16'd250, 16'd3700, 0, 0);
        queue_tick(64'd135, 1, 0, 1, 16'd250, 16'd3700, 0, 0);
        queue_tick(64'd5, 1, 1, 1, 16'd250, 16'd3700, 0, 0);
        queue_tick(64'd140, 0, 1, 1, 16'd250, 16'd3700, 0, 0);
        queue_tick(64'd150, 1, 1, 1, 16'd250, 16'd3700, 0, 1);
        queue_tick(64'd160, 1, 1, 1, 16'd250, 16'd3700, 0, 0);
        queue_tick(64'd170, 1, 1, 1, 16'd250, 16'd3700, 0, 1);
        queue_tick(64'd180, 1, 0, 1, 16'd250, 16'd3700, 1, 0);
        queue_tick(64'd190, 0, 1, 1, 16'd250, 16'd3700, 0, 0);
        queue_tick(64'd200, 1, 1, 0, 16'd250, 16'd3700, 0, 0);
        queue_tick(64'd210, 0, 1, 1, 16'd250, 16'd3700, 0, 0);
        queue_tick(64'd220, 1, 1, 1, 16'h8000, 16'd3700, 0, 0);
        queue_tick(64'd230, 0, 1, 1, 16'd250, 16'd3700, 0, 0);
        queue_tick(64'd240, 1, 1, 1, 16'd451, 16'hFFFF, 0, 0);
        queue_tick(64'd250, 0, 1, 1, 16'd250, 16'd3700, 0, 0);
        queue_tick(64'd260, 1, 1, 1, 16'd250, 16'd4201, 0, 0);
        queue_tick(64'd270, 0, 1, 1, 16'd250, 16'd3700, 0, 0);
        queue_tick(64'd280, 1, 1, 1, 16'd250, 16'd3700, 1, 1);
        queue_tick(64'd290, 0, 1, 1, 16'd250, 16'd3700, 0, 0);
        queue_tick(64'd290, 1, 1, 1, 16'd250, 16'd3700, 0, 0);
        clock_ms = 64'd300;

        // Ordinary limits with a short charge timer.
        apply_limits(-16'sd200, 16'sd600, 16'd2800, 16'd4300,
                     32'($urandom_range(300, 3000)));
        gen_phase(200);

        // Widest windows and the longest timer, with the clock far from zero.
        apply_limits(16'sh8000, 16'sh7FFF, 16'd0, 16'hFFFF, 32'hFFFF_FFFF);
        clock_ms = 64'h5555_5555_5555_5555;
        gen_phase(180);

        // Inverted temperature window: every reading fails it.
        apply_limits(16'sd200, -16'sd200, 16'd3000, 16'd4200, 32'd1000);
        gen_phase(50);

        // Zero timer: any later tick in active times out.
        apply_limits(-16'sd400, 16'sh7FFF, 16'd3000, 16'd4200, 32'd0);
        clock_ms = 64'hAAAA_AAAA_AAAA_AAAA;
        gen_phase(120);

        // Inverted voltage window.
        apply_limits(16'sh8000, 16'sd450, 16'd4200, 16'd3000, 32'd50);
        gen_phase(50);

        // Last part: reset temperature and voltage limits, a timer of 500, no idling, clock near its top.
        apply_limits(MIN_TEMP_RST, MAX_TEMP_RST, MIN_VOLTAGE_RST, MAX_VOLTAGE_RST, 32'd500);
        idle_on  = 1'b0;
        clock_ms = 64'hFFFF_FFFF_FFF0_0000;
        gen_phase(180);
        queue_tick('1, 1, 1, 1, 16'd250, 16'd3700, 0, 0);
        queue_tick('1, 0, 1, 1, 16'd250, 16'd3700, 0, 0);

        // Drain and report.
        while (pend_q.size() != 0 || send_valid || status_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Sent %0d supervision ticks and checked %0d status transactions", ticks_queued,
                 results_seen);
        $display("under %0d limit sets, with inverted windows, zero and maximum timers.",
                 settings_applied);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
design/bcs_pkg.sv
design/bcs_if.sv
design/battery_charge_supervisor.sv
design/bcs_checker.sv
tb/tb_battery_charge_supervisor.sv
